### hw/rtl/rpd_pkg.sv
// ============================================================================
// rpd_pkg
// Shared types and character/result codes for the RSP packet deframer.
// ============================================================================
package rpd_pkg;

  // framing characters
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChEqual  = 8'h3D;

  // result kinds
  localparam logic [2:0] KindField = 3'd0;
  localparam logic [2:0] KindGood  = 3'd1;
  localparam logic [2:0] KindBad   = 3'd2;
  localparam logic [2:0] KindAck   = 3'd3;
  localparam logic [2:0] KindNak   = 3'd4;

  // byte classification produced by the front end
  typedef struct packed {
    logic       is_dollar;
    logic       is_hash;
    logic       is_plus;
    logic       is_minus;
    logic       is_delim;
    logic       hex_ok;
    logic [3:0] hex_val;
  } rpd_class_t;

  // one queue entry
  typedef struct packed {
    logic [7:0] rx_byte;
    rpd_class_t cls;
  } rpd_item_t;

  // one result
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       has_data;
    logic       starts_field;
    logic [7:0] field_delim;
  } rpd_result_t;

endpackage

### hw/rtl/rpd_front.sv
// ============================================================================
// rpd_front
// Input stage: takes link bytes, classifies them and registers the result.
// ============================================================================
module rpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              push_o,
  input  logic              q_full_i,
  output rpd_pkg::rpd_item_t item_o
);
  import rpd_pkg::*;

  logic       stage_valid_q, stage_valid_d;
  rpd_item_t  item_q;
  rpd_class_t cls;

  always_comb begin
    cls           = '0;
    cls.is_dollar = (in_byte_i == ChDollar);
    cls.is_hash   = (in_byte_i == ChHash);
    cls.is_plus   = (in_byte_i == ChPlus);
    cls.is_minus  = (in_byte_i == ChMinus);
    cls.is_delim  = (in_byte_i inside {ChComma, ChColon, ChSemi, ChEqual});
    if (in_byte_i inside {[8'h30 : 8'h39]}) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = in_byte_i[3:0];
    end else if (in_byte_i inside {[8'h61 : 8'h66], [8'h41 : 8'h46]}) begin
      // 'a'..'f' and 'A'..'F' share the low three bits 1..6
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_byte_i[2:0] + 3'd1) + 4'd8;
    end
  end

  assign push_o     = stage_valid_q && !q_full_i;
  assign in_ready_o = !stage_valid_q || !q_full_i;
  assign item_o     = item_q;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_valid_i && in_ready_o) begin
      stage_valid_d = 1'b1;
    end else if (push_o) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.rx_byte <= in_byte_i;
      item_q.cls     <= cls;
    end
  end

endmodule

### hw/rtl/rpd_queue.sv
// ============================================================================
// rpd_queue
// Small FIFO of classified bytes between front end and back end.
// ============================================================================
module rpd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rpd_pkg::rpd_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rpd_pkg::rpd_item_t pop_item_o
);
  import rpd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rpd_item_t          mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o) else $error("push into full queue");

endmodule

### hw/rtl/rpd_back.sv
// ============================================================================
// rpd_back
// Framing state machine: turns classified bytes into field items, verdicts,
// and partner ack/nak, with a registered output.
// ============================================================================
module rpd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  rpd_pkg::rpd_item_t   item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rpd_pkg::rpd_result_t out_o
);
  import rpd_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhBody = 2'd1;
  localparam logic [1:0] PhHi   = 2'd2;
  localparam logic [1:0] PhLo   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  pend_delim_q, pend_delim_d;
  logic        pend_valid_q, pend_valid_d;
  logic        pend_cmd_q, pend_cmd_d;
  logic        started_q, started_d;
  logic [3:0]  hi_nib_q, hi_nib_d;
  logic        hex_err_q, hex_err_d;
  logic        out_valid_q, out_valid_d;
  rpd_result_t out_q, res;
  logic        emit;
  logic [7:0]  b;
  rpd_class_t  c;

  assign b     = item_i.rx_byte;
  assign c     = item_i.cls;
  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d      = phase_q;
    sum_d        = sum_q;
    pend_delim_d = pend_delim_q;
    pend_valid_d = pend_valid_q;
    pend_cmd_d   = pend_cmd_q;
    started_d    = started_q;
    hi_nib_d     = hi_nib_q;
    hex_err_d    = hex_err_q;
    emit         = 1'b0;
    res          = '0;
    case (phase_q)
      PhIdle: begin
        if (c.is_plus) begin
          emit     = 1'b1;
          res.kind = KindAck;
        end else if (c.is_minus) begin
          emit     = 1'b1;
          res.kind = KindNak;
        end else if (c.is_dollar) begin
          phase_d      = PhBody;
          sum_d        = '0;
          pend_delim_d = '0;
          pend_valid_d = 1'b0;
          pend_cmd_d   = 1'b0;
          started_d    = 1'b0;
          hi_nib_d     = '0;
          hex_err_d    = 1'b0;
        end
      end
      PhBody: begin
        if (c.is_hash) begin
          phase_d      = PhHi;
          pend_valid_d = 1'b0;
          pend_cmd_d   = 1'b0;
          // lone command byte still yields one empty field
          if (pend_valid_q && pend_cmd_q) begin
            emit             = 1'b1;
            res.kind         = KindField;
            res.starts_field = 1'b1;
            res.field_delim  = pend_delim_q;
          end
        end else begin
          sum_d = sum_q + b;
          if (!started_q) begin
            started_d    = 1'b1;
            pend_delim_d = b;
            pend_valid_d = 1'b1;
            pend_cmd_d   = 1'b1;
          end else if (c.is_delim) begin
            // back-to-back openers: flush the older one as an empty field
            if (pend_valid_q) begin
              emit             = 1'b1;
              res.kind         = KindField;
              res.starts_field = 1'b1;
              res.field_delim  = pend_delim_q;
            end
            pend_delim_d = b;
            pend_valid_d = 1'b1;
            pend_cmd_d   = 1'b0;
          end else begin
            emit          = 1'b1;
            res.kind      = KindField;
            res.data_byte = b;
            res.has_data  = 1'b1;
            if (pend_valid_q) begin
              res.starts_field = 1'b1;
              res.field_delim  = pend_delim_q;
            end
            pend_valid_d = 1'b0;
            pend_cmd_d   = 1'b0;
          end
        end
      end
      PhHi: begin
        hex_err_d = !c.hex_ok;
        hi_nib_d  = c.hex_val;
        phase_d   = PhLo;
      end
      PhLo: begin
        phase_d = PhIdle;
        emit    = 1'b1;
        if (!hex_err_q && c.hex_ok && ({hi_nib_q, c.hex_val} == sum_q)) begin
          res.kind = KindGood;
        end else begin
          res.kind = KindBad;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      sum_q        <= '0;
      pend_delim_q <= '0;
      pend_valid_q <= 1'b0;
      pend_cmd_q   <= 1'b0;
      started_q    <= 1'b0;
      hi_nib_q     <= '0;
      hex_err_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q      <= phase_d;
        sum_q        <= sum_d;
        pend_delim_q <= pend_delim_d;
        pend_valid_q <= pend_valid_d;
        pend_cmd_q   <= pend_cmd_d;
        started_q    <= started_d;
        hi_nib_q     <= hi_nib_d;
        hex_err_q    <= hex_err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_ctrl_kind_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != KindField |->
      !out_q.has_data && !out_q.starts_field && out_q.field_delim == '0)
    else $error("control result carries field payload");
  a_empty_field_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KindField && !out_q.has_data |-> out_q.starts_field)
    else $error("empty field item without field start");
  a_cmd_pending_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cmd_q |-> pend_valid_q && phase_q == PhBody)
    else $error("command opener pending outside payload");

endmodule

### hw/rtl/rsp_packet_deframer_core.sv
// ============================================================================
// rsp_packet_deframer_core
// Receive-side framing for the debug serial protocol: acks/naks, payload
// field items and checksum verdicts from a stream of link bytes.
// ============================================================================
// Path: a taken byte passes through the front register, then its queue entry is
//   popped into the output register, which drives the master side.
// Throughput: one byte per cycle while the queue has room; the back-end framing
//   state machine consumes one queued byte per cycle whenever its output is free.
// Reset: rst_ni is asynchronous and active low; it empties the queue and the
//   output register and returns the framer to idle (waiting for '$').
module rsp_packet_deframer_core #(
  parameter int unsigned QueueDepth = 4   // classified bytes between the halves
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request input: one link byte per request
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] field_delim
  output logic [4:0]  m_axis_tuser_o    // [2:0] kind, [3] has_data, [4] starts_field
);
  import rpd_pkg::*;

  // front end -> queue
  logic        push;
  logic        q_full;
  rpd_item_t   push_item;
  // queue -> back end
  logic        q_valid;
  logic        pop;
  rpd_item_t   pop_item;
  rpd_result_t result;

  // Classify each byte (framing char, delimiter, hex digit) and stage it.
  rpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .push_o     (push),
    .q_full_i   (q_full),
    .item_o     (push_item)
  );

  // Decouples input acceptance from output back-pressure.
  rpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // Framing state machine: field tracking, running sum, checksum check.
  rpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result)
  );

  assign m_axis_tdata_o = {result.field_delim, result.data_byte};
  assign m_axis_tuser_o = {result.starts_field, result.has_data, result.kind};

endmodule

### verif/rsp_packet_deframer_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// rsp_packet_deframer_core_test
// Self-checking bench for the debug-link packet deframer. A short directed
// table covers idle ack/nak, stray bytes and the framing corner cases. Random
// packets follow, mixed with noise and broken frames. A byte-level model of
// the framer predicts the random results and some directed ones, and random
// stalls on both streams check the handshakes.
// ============================================================================
module rsp_packet_deframer_core_test;
  import rpd_pkg::*;

  localparam int TotalItems = 1200;
  localparam int StallLimit = 2000;   // cycles with no request moving on either side
  localparam int HoldCycles = 60;     // one long receiver hold-off, fills the queue

  typedef enum logic [1:0] {PhIdle, PhBody, PhHi, PhLo} frame_phase_e;
  typedef enum logic [1:0] {RowNone, RowResult, RowPredict} row_check_e;

  typedef struct packed {
    row_check_e  chk;
    logic [7:0]  rx_byte;
    rpd_result_t want;
  } dir_row_t;

  localparam rpd_result_t NoRes   = '0;
  localparam rpd_result_t AckRes  = '{KindAck, 8'h00, 1'b0, 1'b0, 8'h00};
  localparam rpd_result_t NakRes  = '{KindNak, 8'h00, 1'b0, 1'b0, 8'h00};
  localparam rpd_result_t GoodRes = '{KindGood, 8'h00, 1'b0, 1'b0, 8'h00};
  localparam rpd_result_t BadRes  = '{KindBad, 8'h00, 1'b0, 1'b0, 8'h00};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;

  rsp_packet_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Framer model: state mirrored at the block's widths
  // --------------------------------------------------------------------------
  frame_phase_e frm_phase;
  logic [7:0]   frm_sum;
  logic [7:0]   open_byte;     // command or delimiter that opens the next field
  logic         open_valid;
  logic         open_is_cmd;
  logic         cmd_seen;
  logic [3:0]   csum_hi;
  logic         csum_bad;

  rpd_result_t  frame_results_q[$];   // results still owed by the block
  int           mismatch_count = 0;
  int           sent_items = 0;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b0, 4'(b - "0")};
    if (b >= "a" && b <= "f") return {1'b0, 4'(b - "a" + 8'd10)};
    if (b >= "A" && b <= "F") return {1'b0, 4'(b - "A" + 8'd10)};
    return 5'b10000;
  endfunction

  function automatic bit is_delim(input logic [7:0] b);
    return b == ChComma || b == ChColon || b == ChSemi || b == ChEqual;
  endfunction

  function automatic void frame_step(input logic [7:0] b, output bit got,
                                     output rpd_result_t res);
    logic [4:0] d;
    got = 1'b0;
    res = '0;
    case (frm_phase)
      PhIdle: begin
        if (b == ChPlus) begin
          got = 1'b1;
          res.kind = KindAck;
        end else if (b == ChMinus) begin
          got = 1'b1;
          res.kind = KindNak;
        end else if (b == ChDollar) begin
          frm_phase   = PhBody;
          frm_sum     = '0;
          open_byte   = '0;
          open_valid  = 1'b0;
          open_is_cmd = 1'b0;
          cmd_seen    = 1'b0;
          csum_hi     = '0;
          csum_bad    = 1'b0;
        end
      end
      PhBody: begin
        if (b == ChHash) begin
          frm_phase = PhHi;
          // only a lone command survives to the end; a trailing delimiter is dropped
          if (open_valid && open_is_cmd) begin
            got = 1'b1;
            res.kind = KindField;
            res.starts_field = 1'b1;
            res.field_delim = open_byte;
          end
          open_valid  = 1'b0;
          open_is_cmd = 1'b0;
        end else begin
          frm_sum = frm_sum + b;
          if (!cmd_seen) begin
            cmd_seen    = 1'b1;
            open_byte   = b;
            open_valid  = 1'b1;
            open_is_cmd = 1'b1;
          end else if (is_delim(b)) begin
            if (open_valid) begin
              got = 1'b1;
              res.kind = KindField;
              res.starts_field = 1'b1;
              res.field_delim = open_byte;
            end
            open_byte   = b;
            open_valid  = 1'b1;
            open_is_cmd = 1'b0;
          end else begin
            got = 1'b1;
            res.kind = KindField;
            res.data_byte = b;
            res.has_data = 1'b1;
            if (open_valid) begin
              res.starts_field = 1'b1;
              res.field_delim = open_byte;
            end
            open_valid  = 1'b0;
            open_is_cmd = 1'b0;
          end
        end
      end
      PhHi: begin
        d = hex_decode(b);
        csum_bad  = d[4];
        csum_hi   = d[3:0];
        frm_phase = PhLo;
      end
      default: begin
        d = hex_decode(b);
        frm_phase = PhIdle;
        got = 1'b1;
        res.kind = (!csum_bad && !d[4] && {csum_hi, d[3:0]} == frm_sum) ? KindGood : KindBad;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  bit quiet = 1'b0;         // end of run: no idling on either side
  bit calm_tx = 1'b0;
  bit hold_req = 1'b0;
  int steady_left = 0;      // requests to offer back to back

  task automatic send_byte(input logic [7:0] b, input row_check_e chk,
                           input rpd_result_t typed);
    bit got;
    rpd_result_t res;
    int n;
    if (steady_left > 0) begin
      steady_left--;
    end else if (!quiet && !calm_tx && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 5);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_items++;
    frame_step(b, got, res);
    case (chk)
      RowResult:  frame_results_q = {frame_results_q, typed};
      RowPredict: if (got) frame_results_q = {frame_results_q, res};
      default: ;
    endcase
  endtask

  task automatic send_pred(input logic [7:0] b);
    send_byte(b, RowPredict, NoRes);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + nib;
    return ($urandom_range(0, 1) ? "A" : "a") + nib - 8'd10;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    logic [4:0] d;
    c = 8'($urandom_range(0, 255));
    d = hex_decode(c);
    // every hex digit is below 8'h80, so flipping the top bit breaks it
    if (!d[4]) c = c ^ 8'h80;
    return c;
  endfunction

  function automatic logic [7:0] rand_delim();
    case ($urandom_range(0, 3))
      0: return ChComma;
      1: return ChColon;
      2: return ChSemi;
      default: return ChEqual;
    endcase
  endfunction

  // one well-formed frame with random content; the checksum is sometimes spoiled
  task automatic send_frame();
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] csum;
    int len;
    int mode;
    sum = '0;
    send_pred(ChDollar);
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
    for (int k = 0; k < len; k++) begin
      b = ($urandom_range(0, 2) == 0) ? rand_delim() : 8'($urandom_range(0, 255));
      if (b == ChHash) b = b ^ 8'h01;
      sum = sum + b;
      send_pred(b);
    end
    send_pred(ChHash);
    mode = $urandom_range(0, 9);
    csum = (mode == 0) ? sum + 8'($urandom_range(1, 255)) : sum;
    send_pred((mode == 1) ? bad_hex_char() : hex_char(csum[7:4]));
    send_pred((mode == 2) ? bad_hex_char() : hex_char(csum[3:0]));
  endtask

  // directed rows: idle traffic, empty payload, lone command, then a frame
  // whose command is a delimiter, with back-to-back delimiters, a '$' in the
  // payload, a trailing delimiter and a non-hex checksum digit
  dir_row_t dir_rows [25] = '{
    '{RowNone,    8'h00,    NoRes},
    '{RowNone,    8'hFF,    NoRes},
    '{RowNone,    ChHash,   NoRes},
    '{RowResult,  ChPlus,   AckRes},
    '{RowResult,  ChMinus,  NakRes},
    '{RowNone,    ChDollar, NoRes},
    '{RowNone,    ChHash,   NoRes},
    '{RowNone,    "0",      NoRes},
    '{RowResult,  "0",      GoodRes},
    '{RowNone,    ChDollar, NoRes},
    '{RowNone,    "g",      NoRes},
    '{RowResult,  ChHash,   '{KindField, 8'h00, 1'b0, 1'b1, "g"}},
    '{RowNone,    "6",      NoRes},
    '{RowResult,  "7",      GoodRes},
    '{RowNone,    ChDollar, NoRes},
    '{RowNone,    ChComma,  NoRes},
    '{RowPredict, ChSemi,   NoRes},
    '{RowPredict, "x",      NoRes},
    '{RowPredict, 8'hFF,    NoRes},
    '{RowPredict, ChDollar, NoRes},
    '{RowPredict, ChColon,  NoRes},
    '{RowPredict, ChEqual,  NoRes},
    '{RowNone,    ChHash,   NoRes},
    '{RowNone,    "Z",      NoRes},
    '{RowResult,  "0",      BadRes}
  };

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    frm_phase     = PhIdle;
    frm_sum       = '0;
    open_byte     = '0;
    open_valid    = 1'b0;
    open_is_cmd   = 1'b0;
    cmd_seen      = 1'b0;
    csum_hi       = '0;
    csum_bad      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx_byte, dir_rows[i].chk, dir_rows[i].want);

    // receiver holds off while requests keep coming: queue fills, input stalls
    hold_req    = 1'b1;
    steady_left = HoldCycles;

    while (sent_items < TotalItems) begin
      if (sent_items > TotalItems - 150) quiet = 1'b1;
      if ($urandom_range(0, 15) == 0) calm_tx = !calm_tx;
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_pred(8'($urandom_range(0, 255)));
        1: send_pred($urandom_range(0, 1) ? ChPlus : ChMinus);
        2: begin
          // frame cut short; whatever follows lands in its payload
          send_pred(ChDollar);
          repeat ($urandom_range(0, 3)) send_pred(8'($urandom_range(0, 255)));
        end
        default: send_frame();
      endcase
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, calm stretches, one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    bit calm_rx;
    bit hold_done;
    calm_rx = 1'b0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!quiet && !calm_rx && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rpd_result_t seen;
    rpd_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      seen.kind         = m_axis_tuser_o[2:0];
      seen.has_data     = m_axis_tuser_o[3];
      seen.starts_field = m_axis_tuser_o[4];
      seen.data_byte    = m_axis_tdata_o[7:0];
      seen.field_delim  = m_axis_tdata_o[15:8];
      if (frame_results_q.size() == 0) begin
        $display("%0t: expected no result, got kind %0d data %0h delim %0h", $time,
                 seen.kind, seen.data_byte, seen.field_delim);
        mismatch_count++;
      end else begin
        want = frame_results_q[0];
        frame_results_q.delete(0);
        check_field("kind", want.kind, seen.kind);
        check_field("data_byte", want.data_byte, seen.data_byte);
        check_field("has_data", want.has_data, seen.has_data);
        check_field("starts_field", want.starts_field, seen.starts_field);
        check_field("field_delim", want.field_delim, seen.field_delim);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: timeout, %0d results still expected", $time, frame_results_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

### sim.f
hw/rtl/rpd_pkg.sv
hw/rtl/rpd_front.sv
hw/rtl/rpd_queue.sv
hw/rtl/rpd_back.sv
hw/rtl/rsp_packet_deframer_core.sv
verif/rsp_packet_deframer_core_test.sv
